// ===== rtl/mlp_relu_inference_unit_defines.svh =====
// Assertion macros for the perceptron RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MLP_RELU_INFERENCE_UNIT_DEFINES_SVH
`define MLP_RELU_INFERENCE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MRI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mri check failed");

// Next-cycle implication, disabled while reset is low.
`define MRI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mri check failed");

`endif

// ===== rtl/mri_pkg.sv =====
// Package for the perceptron inference unit: beat types, command/status
// structs and fixed-point constants. No dependencies.
`default_nettype none

package mri_pkg;

    localparam int DEF_NUM_INPUTS = 4;
    localparam int DEF_NUM_HIDDEN = 16;
    localparam int FRAC_BITS      = 12;
    localparam int Q_W            = 16;
    localparam int PROD_W         = 2 * Q_W;
    localparam int IDX_W          = 7;
    localparam int NUM_FEATURES   = 4;
    localparam int Q_MAX          = 32767;
    localparam int Q_MIN          = -32768;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [IDX_W-1:0]        param_index;
        logic signed [Q_W-1:0]   param_value;
        logic signed [Q_W-1:0]   feature_0;
        logic signed [Q_W-1:0]   feature_1;
        logic signed [Q_W-1:0]   feature_2;
        logic signed [Q_W-1:0]   feature_3;
    } mri_in_t;

    typedef struct packed {
        logic signed [Q_W-1:0]   net_output;
        logic                    output_saturated;
    } mri_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // write one parameter from the input beat
        logic start;   // latch features of an evaluate beat
        logic issue;   // one multiply-accumulate term enters the pipe
        logic layer;   // 0: hidden layer term, 1: output layer term
        logic first;   // first term of a unit: seed with the bias
        logic last;    // last term of a hidden unit: write activation
        logic emit;    // move the output sum to the result register
    } mri_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } mri_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mri_ctrl.sv =====
// Sequencer for the perceptron unit: walks hidden and output terms.
// Depends on mri_pkg and mlp_relu_inference_unit_defines.svh.
`default_nettype none
`include "mlp_relu_inference_unit_defines.svh"

module mri_ctrl #(
    parameter int  NUM_INPUTS = mri_pkg::DEF_NUM_INPUTS,
    parameter int  NUM_HIDDEN = mri_pkg::DEF_NUM_HIDDEN,
    localparam int HID_W      = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1,
    localparam int IN_W       = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1,
    localparam int L1_AW      = (NUM_INPUTS * NUM_HIDDEN > 1) ?
                                $clog2(NUM_INPUTS * NUM_HIDDEN) : 1
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic                        s_op,
    output logic                             s_ready,
    input  wire mri_pkg::mri_stat_t          stat,
    output mri_pkg::mri_cmd_t                cmd,
    output logic [HID_W-1:0]                 cmd_unit,
    output logic [IN_W-1:0]                  cmd_j,
    output logic [L1_AW-1:0]                 cmd_l1_addr
);

    localparam logic [HID_W-1:0] UNIT_LAST = HID_W'(NUM_HIDDEN - 1);
    localparam logic [IN_W-1:0]  J_LAST    = IN_W'(NUM_INPUTS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_L1     = 3'd1;
    localparam logic [2:0] ST_DRAIN1 = 3'd2;
    localparam logic [2:0] ST_L2     = 3'd3;
    localparam logic [2:0] ST_DRAIN2 = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [HID_W-1:0] unit_reg, unit_next;
    logic [IN_W-1:0]  j_reg, j_next;
    logic [L1_AW-1:0] addr_reg, addr_next;

    always_comb begin
        state_next = state_reg;
        unit_next  = unit_reg;
        j_next     = j_reg;
        addr_next  = addr_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == mri_pkg::OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        unit_next  = '0;
                        j_next     = '0;
                        addr_next  = '0;
                        state_next = ST_L1;
                    end
                end
            end
            ST_L1: begin
                cmd.issue = 1'b1;
                cmd.layer = 1'b0;
                cmd.first = (j_reg == '0);
                cmd.last  = (j_reg == J_LAST);
                addr_next = addr_reg + 1'b1;
                if (j_reg == J_LAST) begin
                    j_next = '0;
                    if (unit_reg == UNIT_LAST) begin
                        unit_next  = '0;
                        state_next = ST_DRAIN1;
                    end else begin
                        unit_next = unit_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN1: begin
                // hidden activations must be written before the output layer reads them
                if (!stat.pipe_busy) begin
                    state_next = ST_L2;
                end
            end
            ST_L2: begin
                cmd.issue = 1'b1;
                cmd.layer = 1'b1;
                cmd.first = (unit_reg == '0);
                if (unit_reg == UNIT_LAST) begin
                    unit_next  = '0;
                    state_next = ST_DRAIN2;
                end else begin
                    unit_next = unit_reg + 1'b1;
                end
            end
            ST_DRAIN2: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cmd_unit    = unit_reg;
    assign cmd_j       = j_reg;
    assign cmd_l1_addr = addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            unit_reg  <= '0;
            j_reg     <= '0;
            addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            unit_reg  <= unit_next;
            j_reg     <= j_next;
            addr_reg  <= addr_next;
        end
    end

    `MRI_ASSERT_NOW(a_idle_pipe_empty, aclk, aresetn, s_ready, !stat.pipe_busy)
    `MRI_ASSERT_NOW(a_emit_slot_free, aclk, aresetn, cmd.emit, stat.out_free)
    `MRI_ASSERT_NEXT(a_emit_then_idle, aclk, aresetn, cmd.emit, s_ready)
    `MRI_ASSERT_NOW(a_l2_after_drain, aclk, aresetn, cmd.issue && cmd.layer && cmd.first, !stat.pipe_busy)

endmodule

`default_nettype wire

// ===== rtl/mri_datapath.sv =====
// Datapath for the perceptron unit: parameter stores, shared MAC pipe,
// activation store and result register. Depends on mri_pkg.
`default_nettype none

module mri_datapath #(
    parameter int  NUM_INPUTS = mri_pkg::DEF_NUM_INPUTS,
    parameter int  NUM_HIDDEN = mri_pkg::DEF_NUM_HIDDEN,
    localparam int HID_W      = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1,
    localparam int IN_W       = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1,
    localparam int L1_AW      = (NUM_INPUTS * NUM_HIDDEN > 1) ?
                                $clog2(NUM_INPUTS * NUM_HIDDEN) : 1
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire mri_pkg::mri_cmd_t           cmd,
    input  wire logic [HID_W-1:0]            cmd_unit,
    input  wire logic [IN_W-1:0]             cmd_j,
    input  wire logic [L1_AW-1:0]            cmd_l1_addr,
    input  wire mri_pkg::mri_in_t            s_data,
    output mri_pkg::mri_stat_t               stat,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output mri_pkg::mri_out_t                m_data
);

    localparam int Q_W    = mri_pkg::Q_W;
    localparam int N_L1   = NUM_INPUTS * NUM_HIDDEN;
    localparam int BASE_HB = N_L1;
    localparam int BASE_OW = BASE_HB + NUM_HIDDEN;
    localparam int IDX_OB  = BASE_OW + NUM_HIDDEN;
    localparam int CNT_W   = $clog2(IDX_OB + 1);
    localparam int EXT_W   = ((CNT_W > mri_pkg::IDX_W) ? CNT_W : mri_pkg::IDX_W) + 1;
    localparam int MAXN    = (NUM_HIDDEN > NUM_INPUTS) ? NUM_HIDDEN : NUM_INPUTS;
    localparam int ACC_W   = mri_pkg::PROD_W + $clog2(MAXN + 1);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(mri_pkg::Q_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(mri_pkg::Q_MIN);

    // parameter stores
    logic signed [Q_W-1:0] l1_mem  [N_L1];
    logic signed [Q_W-1:0] hb_mem  [NUM_HIDDEN];
    logic signed [Q_W-1:0] ow_mem  [NUM_HIDDEN];
    logic signed [Q_W-1:0] hid_mem [NUM_HIDDEN];
    logic [NUM_HIDDEN-1:0] hb_vld_reg;
    logic signed [Q_W-1:0] ob_reg;
    logic signed [Q_W-1:0] feat_reg [mri_pkg::NUM_FEATURES];

    // load decode
    logic [EXT_W-1:0] idx_ext, hb_off, ow_off;
    logic             wr_l1, wr_hb, wr_ow, wr_ob;

    assign idx_ext = EXT_W'(s_data.param_index);
    assign hb_off  = idx_ext - EXT_W'(BASE_HB);
    assign ow_off  = idx_ext - EXT_W'(BASE_OW);
    assign wr_l1   = cmd.load && (idx_ext < EXT_W'(BASE_HB));
    assign wr_hb   = cmd.load && (idx_ext >= EXT_W'(BASE_HB)) && (idx_ext < EXT_W'(BASE_OW));
    assign wr_ow   = cmd.load && (idx_ext >= EXT_W'(BASE_OW)) && (idx_ext < EXT_W'(IDX_OB));
    assign wr_ob   = cmd.load && (idx_ext == EXT_W'(IDX_OB));

    always_ff @(posedge aclk) begin
        if (wr_l1) begin
            l1_mem[idx_ext[L1_AW-1:0]] <= s_data.param_value;
        end
        if (wr_hb) begin
            hb_mem[hb_off[HID_W-1:0]] <= s_data.param_value;
        end
        if (wr_ow) begin
            ow_mem[ow_off[HID_W-1:0]] <= s_data.param_value;
        end
        if (cmd.start) begin
            feat_reg[0] <= s_data.feature_0;
            feat_reg[1] <= s_data.feature_1;
            feat_reg[2] <= s_data.feature_2;
            feat_reg[3] <= s_data.feature_3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hb_vld_reg <= '0;
            ob_reg     <= '0;
        end else begin
            if (wr_hb) begin
                hb_vld_reg[hb_off[HID_W-1:0]] <= 1'b1;
            end
            if (wr_ob) begin
                ob_reg <= s_data.param_value;
            end
        end
    end

    // stage 1: store reads
    logic signed [Q_W-1:0] l1_rd_reg, ow_rd_reg, hid_rd_reg, hb_rd_reg;
    logic                  hb_ok_reg;
    logic                  s1_vld_reg, s1_layer_reg, s1_first_reg, s1_last_reg;
    logic [HID_W-1:0]      s1_unit_reg;
    logic [IN_W-1:0]       s1_j_reg;

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            l1_rd_reg  <= l1_mem[cmd_l1_addr];
            ow_rd_reg  <= ow_mem[cmd_unit];
            hid_rd_reg <= hid_mem[cmd_unit];
            hb_rd_reg  <= hb_mem[cmd_unit];
            hb_ok_reg  <= hb_vld_reg[cmd_unit];
        end
        s1_layer_reg <= cmd.layer;
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_unit_reg  <= cmd_unit;
        s1_j_reg     <= cmd_j;
    end

    // stage 2: product
    logic [4:0]                         j_ext;
    logic signed [Q_W-1:0]              feat_sel, op_w, op_x, bias_sel;
    logic signed [mri_pkg::PROD_W-1:0]  s2_prod_reg;
    logic signed [Q_W-1:0]              s2_bias_reg;
    logic                               s2_vld_reg, s2_layer_reg, s2_first_reg, s2_last_reg;
    logic [HID_W-1:0]                   s2_unit_reg;

    assign j_ext    = 5'(s1_j_reg);
    // features past the fourth read as zero
    assign feat_sel = (j_ext < 5'(mri_pkg::NUM_FEATURES)) ? feat_reg[j_ext[1:0]] : '0;
    assign op_w     = s1_layer_reg ? ow_rd_reg : l1_rd_reg;
    assign op_x     = s1_layer_reg ? hid_rd_reg : feat_sel;
    assign bias_sel = s1_layer_reg ? ob_reg : (hb_ok_reg ? hb_rd_reg : '0);

    always_ff @(posedge aclk) begin
        s2_prod_reg  <= op_w * op_x;
        s2_bias_reg  <= bias_sel;
        s2_layer_reg <= s1_layer_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_unit_reg  <= s1_unit_reg;
    end

    // stage 3: accumulate
    logic signed [ACC_W-1:0] acc_reg, acc_next, bias_ext, acc_sh;
    logic                    s3_vld_reg, s3_fin_reg;
    logic [HID_W-1:0]        s3_unit_reg;

    assign bias_ext = ACC_W'(s2_bias_reg);
    assign acc_next = (s2_first_reg ? (bias_ext <<< mri_pkg::FRAC_BITS) : acc_reg)
                      + ACC_W'(s2_prod_reg);

    always_ff @(posedge aclk) begin
        if (s2_vld_reg) begin
            acc_reg <= acc_next;
        end
        s3_unit_reg <= s2_unit_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s3_fin_reg <= 1'b0;
        end else begin
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s3_fin_reg <= s2_vld_reg && !s2_layer_reg && s2_last_reg;
        end
    end

    // stage 4: ReLU and clip into the activation store
    logic signed [Q_W-1:0] hid_val;

    assign acc_sh = acc_reg >>> mri_pkg::FRAC_BITS;

    always_comb begin
        if (acc_reg[ACC_W-1]) begin
            hid_val = '0;
        end else if (acc_sh > SAT_HI) begin
            hid_val = Q_W'(mri_pkg::Q_MAX);
        end else begin
            hid_val = acc_sh[Q_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_fin_reg) begin
            hid_mem[s3_unit_reg] <= hid_val;
        end
    end

    // result register
    mri_pkg::mri_out_t out_next;
    logic              m_valid_reg;
    mri_pkg::mri_out_t m_data_reg;

    always_comb begin
        if (acc_sh > SAT_HI) begin
            out_next.net_output       = Q_W'(mri_pkg::Q_MAX);
            out_next.output_saturated = 1'b1;
        end else if (acc_sh < SAT_LO) begin
            out_next.net_output       = Q_W'(mri_pkg::Q_MIN);
            out_next.output_saturated = 1'b1;
        end else begin
            out_next.net_output       = acc_sh[Q_W-1:0];
            out_next.output_saturated = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;
    assign stat.pipe_busy = s1_vld_reg || s2_vld_reg || s3_vld_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

// ===== rtl/mlp_relu_inference_unit.sv =====
// Top level of the two-layer ReLU perceptron inference unit.
// Depends on mri_pkg, mri_ctrl and mri_datapath.
`default_nettype none

// A load beat (op = 0) writes one weight or bias and is taken as soon as
// it is offered; the next beat can follow at once. An evaluate beat (op = 1)
// runs the hidden-layer terms, a pipe drain, the output-layer terms, a second
// pipe drain and the hand-off into the result register, all through the one
// shared 16x16 multiply-accumulate pipe that handles one product a cycle.
// Input is refused while an evaluation
// runs; the result waits in its own register, so the next beat may be taken
// before it is collected. Hidden and output biases read as zero until loaded;
// loads with an index past the output bias are dropped.
module mlp_relu_inference_unit #(
    parameter int NUM_INPUTS = mri_pkg::DEF_NUM_INPUTS,
    parameter int NUM_HIDDEN = mri_pkg::DEF_NUM_HIDDEN
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire mri_pkg::mri_in_t     s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output mri_pkg::mri_out_t         m_data
);

    localparam int HID_W = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
    localparam int IN_W  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int L1_AW = (NUM_INPUTS * NUM_HIDDEN > 1) ?
                           $clog2(NUM_INPUTS * NUM_HIDDEN) : 1;

    mri_pkg::mri_cmd_t  cmd;
    mri_pkg::mri_stat_t stat;
    logic [HID_W-1:0]   cmd_unit;
    logic [IN_W-1:0]    cmd_j;
    logic [L1_AW-1:0]   cmd_l1_addr;

    mri_ctrl #(
        .NUM_INPUTS (NUM_INPUTS),
        .NUM_HIDDEN (NUM_HIDDEN)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_op        (s_data.op),
        .s_ready     (s_ready),
        .stat        (stat),
        .cmd         (cmd),
        .cmd_unit    (cmd_unit),
        .cmd_j       (cmd_j),
        .cmd_l1_addr (cmd_l1_addr)
    );

    mri_datapath #(
        .NUM_INPUTS (NUM_INPUTS),
        .NUM_HIDDEN (NUM_HIDDEN)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cmd_unit    (cmd_unit),
        .cmd_j       (cmd_j),
        .cmd_l1_addr (cmd_l1_addr),
        .s_data      (s_data),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// ===== dv/tb_mlp_relu_inference_unit.sv =====
// Self-checking testbench for mlp_relu_inference_unit: parameter loads and
// evaluations against a local Q4.12 forward-pass predictor.
// Depends on mri_pkg and the mlp_relu_inference_unit RTL.
module tb_mlp_relu_inference_unit;

    localparam int NUM_IN       = mri_pkg::DEF_NUM_INPUTS;
    localparam int NUM_HID      = mri_pkg::DEF_NUM_HIDDEN;
    localparam int Q_W          = mri_pkg::Q_W;
    localparam int IDX_W        = mri_pkg::IDX_W;
    localparam int FRAC_BITS    = mri_pkg::FRAC_BITS;
    localparam int Q_MAX        = mri_pkg::Q_MAX;
    localparam int Q_MIN        = mri_pkg::Q_MIN;
    localparam int HB_BASE      = NUM_HID * NUM_IN;
    localparam int OW_BASE      = HB_BASE + NUM_HID;
    localparam int OB_IDX       = OW_BASE + NUM_HID;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_BEATS = 1150;
    localparam int CYCLE_LIMIT  = 5000000;

    // Value scales for parameters and features
    localparam int SCALE_SMALL  = 0;
    localparam int SCALE_MEDIUM = 1;
    localparam int SCALE_FULL   = 2;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    mri_pkg::mri_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    mri_pkg::mri_out_t m_data;

    // Shadow copy of the network parameters
    logic signed [Q_W-1:0] l1_w [HB_BASE];
    logic signed [Q_W-1:0] hid_b [NUM_HID];
    logic signed [Q_W-1:0] out_w [NUM_HID];
    logic signed [Q_W-1:0] out_b;

    mri_pkg::mri_out_t expected_outputs [$];
    int       fail_count  = 0;
    int       cycle_count = 0;
    int       stall_left  = 0;
    bit       tx_calm     = 1'b0;
    bit       rx_calm     = 1'b0;

    mlp_relu_inference_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 20);
        return $urandom_range(21, 150);
    endfunction

    function automatic int rand_q(input int scale);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 4))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return 0;
                3: return -1;
                default: return 1;
            endcase
        end
        case (scale)
            SCALE_SMALL:  return int'($urandom_range(0, 4096)) - 2048;
            SCALE_MEDIUM: return int'($urandom_range(0, 32768)) - 16384;
            default:      return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic mri_pkg::mri_in_t load_beat(input int idx, input int val);
        mri_pkg::mri_in_t beat;
        beat.op          = mri_pkg::OP_LOAD;
        beat.param_index = idx[IDX_W-1:0];
        beat.param_value = val[Q_W-1:0];
        beat.feature_0   = $urandom;
        beat.feature_1   = $urandom;
        beat.feature_2   = $urandom;
        beat.feature_3   = $urandom;
        return beat;
    endfunction

    function automatic mri_pkg::mri_in_t eval_beat(input int f0, input int f1, input int f2,
                                                   input int f3);
        mri_pkg::mri_in_t beat;
        beat.op          = mri_pkg::OP_EVAL;
        beat.param_index = $urandom;
        beat.param_value = $urandom;
        beat.feature_0   = f0[Q_W-1:0];
        beat.feature_1   = f1[Q_W-1:0];
        beat.feature_2   = f2[Q_W-1:0];
        beat.feature_3   = f3[Q_W-1:0];
        return beat;
    endfunction

    function automatic void store_param(input logic [IDX_W-1:0] idx,
                                        input logic signed [Q_W-1:0] val);
        // Drop indices past the output bias
        if (idx < HB_BASE)      l1_w[idx] = val;
        else if (idx < OW_BASE) hid_b[idx - HB_BASE] = val;
        else if (idx < OB_IDX)  out_w[idx - OW_BASE] = val;
        else if (idx == OB_IDX) out_b = val;
    endfunction

    function automatic mri_pkg::mri_out_t predict_net_output(input mri_pkg::mri_in_t beat);
        longint            feat [NUM_IN];
        longint            hid [NUM_HID];
        longint            acc;
        longint            v;
        mri_pkg::mri_out_t res;
        feat[0] = longint'($signed(beat.feature_0));
        feat[1] = longint'($signed(beat.feature_1));
        feat[2] = longint'($signed(beat.feature_2));
        feat[3] = longint'($signed(beat.feature_3));
        for (int h = 0; h < NUM_HID; h++) begin
            acc = longint'(hid_b[h]) * (longint'(1) << FRAC_BITS);
            for (int i = 0; i < NUM_IN; i++)
                acc += longint'(l1_w[h*NUM_IN + i]) * feat[i];
            v = acc >>> FRAC_BITS;
            if (v < 0) v = 0;
            if (v > Q_MAX) v = Q_MAX;
            hid[h] = v;
        end
        acc = longint'(out_b) * (longint'(1) << FRAC_BITS);
        for (int h = 0; h < NUM_HID; h++)
            acc += longint'(out_w[h]) * hid[h];
        v = acc >>> FRAC_BITS;
        res.output_saturated = 1'b0;
        if (v > Q_MAX) begin
            v = Q_MAX;
            res.output_saturated = 1'b1;
        end else if (v < Q_MIN) begin
            v = Q_MIN;
            res.output_saturated = 1'b1;
        end
        res.net_output = v[Q_W-1:0];
        return res;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", msg);
    endtask

    // Keep valid high across back-to-back beats; lower it only for a gap
    task automatic send_beat(input mri_pkg::mri_in_t beat);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        if (beat.op == mri_pkg::OP_EVAL)
            expected_outputs = {expected_outputs, predict_net_output(beat)};
        else
            store_param(beat.param_index, beat.param_value);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        mri_pkg::mri_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                report_failure($sformatf("result beat with none expected: out=%0d sat=%0b",
                                         $signed(m_data.net_output),
                                         m_data.output_saturated));
            end else begin
                want = expected_outputs.pop_front();
                if (m_data.net_output !== want.net_output)
                    report_failure($sformatf("net_output expected %0d got %0d",
                                             $signed(want.net_output),
                                             $signed(m_data.net_output)));
                if (m_data.output_saturated !== want.output_saturated)
                    report_failure($sformatf("output_saturated expected %0b got %0b",
                                             want.output_saturated,
                                             m_data.output_saturated));
            end
        end
    end

    // Write every weight, leave the biases at their reset value of zero
    task automatic test_zero_biases();
        for (int i = 0; i < HB_BASE; i++) send_beat(load_beat(i, rand_q(SCALE_SMALL)));
        for (int h = 0; h < NUM_HID; h++)
            send_beat(load_beat(OW_BASE + h, rand_q(SCALE_SMALL)));
        send_beat(eval_beat(0, 0, 0, 0));
        repeat (3)
            send_beat(eval_beat(rand_q(SCALE_SMALL), rand_q(SCALE_SMALL),
                                rand_q(SCALE_SMALL), rand_q(SCALE_SMALL)));
    endtask

    task automatic test_feature_extremes();
        send_beat(eval_beat(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_beat(eval_beat(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_beat(eval_beat(Q_MAX, Q_MIN, 0, -1));
        send_beat(eval_beat(-1, 1, Q_MIN, Q_MAX));
    endtask

    // Hidden unit 0 driven far past full scale; output weight of 1.0 shows
    // the clipped activation without setting the flag
    task automatic test_hidden_clip();
        for (int i = 0; i < NUM_IN; i++) send_beat(load_beat(i, Q_MAX));
        send_beat(load_beat(HB_BASE, Q_MAX));
        send_beat(load_beat(OW_BASE, 1 << FRAC_BITS));
        for (int h = 1; h < NUM_HID; h++) send_beat(load_beat(OW_BASE + h, 0));
        send_beat(eval_beat(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_beat(eval_beat(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    endtask

    task automatic test_output_clip();
        send_beat(load_beat(OW_BASE, Q_MAX));
        send_beat(load_beat(OB_IDX, Q_MAX));
        send_beat(eval_beat(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_beat(load_beat(OW_BASE, Q_MIN));
        send_beat(load_beat(OB_IDX, Q_MIN));
        send_beat(eval_beat(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        // Hidden unit 0 at zero leaves only the bias: full scale, no clip
        send_beat(eval_beat(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_beat(load_beat(OB_IDX, Q_MAX));
        send_beat(eval_beat(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    endtask

    task automatic test_bad_index();
        send_beat(load_beat(OB_IDX + 1, rand_q(SCALE_FULL)));
        send_beat(load_beat((1 << IDX_W) - 1, rand_q(SCALE_FULL)));
        send_beat(load_beat($urandom_range(OB_IDX + 2, (1 << IDX_W) - 2),
                            rand_q(SCALE_FULL)));
        send_beat(eval_beat(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    endtask

    // Bursts share one value scale and one idling mode
    task automatic test_random_traffic();
        int sent;
        int burst;
        int scale;
        int r;
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            r = $urandom_range(0, 9);
            scale   = (r < 5) ? SCALE_SMALL : (r < 8) ? SCALE_MEDIUM : SCALE_FULL;
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            burst   = $urandom_range(20, 80);
            repeat (burst) begin
                if ($urandom_range(0, 99) < 35)
                    send_beat(load_beat($urandom_range(0, (1 << IDX_W) - 1), rand_q(scale)));
                else
                    send_beat(eval_beat(rand_q(scale), rand_q(scale),
                                        rand_q(scale), rand_q(scale)));
                sent++;
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial begin
        out_b = '0;
        for (int h = 0; h < NUM_HID; h++) hid_b[h] = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_zero_biases();
        test_feature_extremes();
        test_hidden_clip();
        test_output_clip();
        test_bad_index();
        test_random_traffic();

        s_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
